// ----- rtl/wildcard_byte_pattern_scan_macros.svh -----
// Assertion macros shared by the pattern scan RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wbps: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wbps: next-cycle check failed");

`endif

// ----- rtl/wbps_pkg.sv -----
// Shared types and constants for the wildcard byte pattern scan.
// No dependencies; used by wbps_match and wildcard_byte_pattern_scan.
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int PAT_REG_BYTES = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int LEN_CFG_W     = 6;
    localparam int RESULT_OFF_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_WORD_0 = 3'd0,
        REG_PATTERN_WORD_1 = 3'd1,
        REG_PATTERN_WORD_2 = 3'd2,
        REG_PATTERN_WORD_3 = 3'd3,
        REG_CARE_MASK      = 3'd4,
        REG_PATTERN_LENGTH = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [PAT_REG_BYTES*8-1:0] pattern;
        logic [PAT_REG_BYTES-1:0]   care;
        logic [LEN_CFG_W-1:0]       length;
    } t_cfg;

endpackage

// ----- rtl/wbps_match.sv -----
// Masked compare of the byte window against the configured pattern.
// Depends on wbps_pkg for the configuration struct.
`timescale 1ns / 1ps

module wbps_match #(
    parameter int MAX_PATTERN_BYTES = 32
) (
    input  logic [MAX_PATTERN_BYTES*8-1:0]        i_window,
    input  wbps_pkg::t_cfg                        i_cfg,
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] i_len,
    output logic                                  o_hit
);

    localparam int WIN_W = MAX_PATTERN_BYTES * 8;
    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    logic [WIN_W-1:0]             w_rev;
    logic [WIN_W-1:0]             w_aligned;
    logic [LEN_W-1:0]             w_shift;
    logic [MAX_PATTERN_BYTES-1:0] w_ok;

    // oldest window byte lands in the lowest slot
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_rev
        assign w_rev[8*k +: 8] = i_window[8*(MAX_PATTERN_BYTES-1-k) +: 8];
    end

    // drop the bytes older than the pattern; pattern byte j then sits in slot j
    assign w_shift   = LEN_W'(MAX_PATTERN_BYTES) - i_len;
    assign w_aligned = w_rev >> {w_shift, 3'b000};

    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cmp
        if (j < wbps_pkg::PAT_REG_BYTES) begin : g_reg
            assign w_ok[j] = (i_len <= LEN_W'(j)) || !i_cfg.care[j]
                          || (i_cfg.pattern[8*j +: 8] == w_aligned[8*j +: 8]);
        end else begin : g_wild
            assign w_ok[j] = 1'b1;
        end
    end

    assign o_hit = &w_ok;

endmodule

// ----- rtl/wildcard_byte_pattern_scan.sv -----
// Top level of the wildcard byte pattern scan.
// Depends on wbps_pkg, wbps_match and wildcard_byte_pattern_scan_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one buffer byte per transfer,
//   with i_last_byte marking the final byte of a buffer. Output channel
//   (o_out_valid / i_out_ready) carries at most one result per buffer: found with
//   the start offset of the first match, or not found (offset 0) on the last byte.
//   Bytes after a reported match are dropped until the buffer ends.
//   The user writes pattern, care mask and length through the cfg port only while
//   the block is idle (not enforced); writes take effect at the next clock edge.
//   The byte that completes a result is registered in the window stage, and the
//   result is then registered in the output register once that register is free.
//   Throughput: one byte per cycle while the receiver does not stall; the window
//   shift register feeds the masked compare behind it.
//   Reset clears the byte count, the reported flag, the valid flags of both pipeline
//   stages and the configuration (length 1, everything else zero).
//   When the receiver stalls, one result is held in the output register and one
//   byte in the window stage; o_in_ready then drops until the output is taken.
//
module wildcard_byte_pattern_scan #(
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int OFFSET_BITS       = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [wbps_pkg::RESULT_OFF_W-1:0]   o_match_offset
);

`include "wildcard_byte_pattern_scan_macros.svh"

    localparam int WIN_W = MAX_PATTERN_BYTES * 8;
    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CMP_W = (LEN_W > wbps_pkg::LEN_CFG_W) ? LEN_W : wbps_pkg::LEN_CFG_W;
    localparam logic [OFFSET_BITS-1:0] SEEN_MAX = {OFFSET_BITS{1'b1}};

    wbps_pkg::t_cfg r_cfg;

    logic [WIN_W-1:0]       r_window, n_window;
    logic [OFFSET_BITS-1:0] r_seen,   n_seen;
    logic                   r_s1_valid, n_s1_valid;
    logic                   r_s1_last,  n_s1_last;
    logic                   r_reported, n_reported;
    logic                   r_out_valid, n_out_valid;
    logic                   r_found,     n_found;
    logic [wbps_pkg::RESULT_OFF_W-1:0] r_offset, n_offset;

    logic [LEN_W-1:0]       w_len;
    logic                   w_hit;
    logic                   w_hit_ok;
    logic                   w_produce;
    logic                   w_out_free;
    logic                   w_in_fire;
    logic                   w_s1_fire;
    logic [OFFSET_BITS-1:0] w_diff;
    logic [63:0]            w_diff_ext;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= '0;
            r_cfg.care    <= '0;
            r_cfg.length  <= wbps_pkg::LEN_CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            case (wbps_pkg::t_cfg_reg'(i_cfg_index))
                wbps_pkg::REG_PATTERN_WORD_0: r_cfg.pattern[63:0]    <= i_cfg_wdata;
                wbps_pkg::REG_PATTERN_WORD_1: r_cfg.pattern[127:64]  <= i_cfg_wdata;
                wbps_pkg::REG_PATTERN_WORD_2: r_cfg.pattern[191:128] <= i_cfg_wdata;
                wbps_pkg::REG_PATTERN_WORD_3: r_cfg.pattern[255:192] <= i_cfg_wdata;
                wbps_pkg::REG_CARE_MASK:      r_cfg.care   <= i_cfg_wdata[31:0];
                wbps_pkg::REG_PATTERN_LENGTH: r_cfg.length <= i_cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // clamp the programmed length to 1..MAX_PATTERN_BYTES
    always_comb begin
        if (r_cfg.length == '0) begin
            w_len = LEN_W'(1);
        end else if (CMP_W'(r_cfg.length) > CMP_W'(MAX_PATTERN_BYTES)) begin
            w_len = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            w_len = LEN_W'(r_cfg.length);
        end
    end

    wbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .i_window (r_window),
        .i_cfg    (r_cfg),
        .i_len    (w_len),
        .o_hit    (w_hit)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_fire  = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_hit_ok   = !r_reported && (r_seen >= OFFSET_BITS'(w_len)) && w_hit;
    assign w_produce  = w_hit_ok || (r_s1_last && !r_reported);
    assign w_diff     = r_seen - OFFSET_BITS'(w_len);
    assign w_diff_ext = 64'(w_diff);

    always_comb begin
        n_window    = r_window;
        n_seen      = r_seen;
        n_s1_valid  = r_s1_valid;
        n_s1_last   = r_s1_last;
        n_reported  = r_reported;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_offset    = r_offset;

        // window stage: shift in the byte, restart the count after a buffer end
        if (w_in_fire) begin
            n_window   = {r_window[WIN_W-9:0], i_data_byte};
            n_s1_last  = i_last_byte;
            n_s1_valid = 1'b1;
            if (r_s1_last) begin
                n_seen = OFFSET_BITS'(1);
            end else if (r_seen != SEEN_MAX) begin
                n_seen = r_seen + OFFSET_BITS'(1);
            end
        end else if (w_s1_fire) begin
            n_s1_valid = 1'b0;
        end

        // result stage
        if (w_s1_fire) begin
            n_out_valid = w_produce;
            n_found     = w_hit_ok;
            n_offset    = w_hit_ok ? w_diff_ext[wbps_pkg::RESULT_OFF_W-1:0] : '0;
            n_reported  = r_s1_last ? 1'b0 : (r_reported || w_hit_ok);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen      <= n_seen;
            r_s1_valid  <= n_s1_valid;
            r_s1_last   <= n_s1_last;
            r_reported  <= n_reported;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
        r_found  <= n_found;
        r_offset <= n_offset;
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

    `WBPS_ASSERT_NOW(a_stage_has_count, i_clk, i_rst_n, r_s1_valid, r_seen != '0)
    `WBPS_ASSERT_NOW(a_stall_source, i_clk, i_rst_n, !o_in_ready, r_s1_valid && r_out_valid)
    `WBPS_ASSERT_NOW(a_miss_offset_zero, i_clk, i_rst_n, o_out_valid && !o_found, o_match_offset == '0)
    `WBPS_ASSERT_NEXT(a_hit_marks_reported, i_clk, i_rst_n, w_s1_fire && w_hit_ok && !r_s1_last, r_reported)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for wildcard_byte_pattern_scan: buffers of bytes go in, found/offset out.
// A scoreboard class predicts each buffer's result; depends on wbps_pkg and the scan RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int TOTAL_BYTES    = 1250;
    localparam int PHASE_BYTES    = 150;
    localparam int WINDOW_BYTES   = 32;

    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_cfg_wr_en    = 1'b0;
    logic [wbps_pkg::CFG_INDEX_W-1:0]  i_cfg_index    = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_wdata    = '0;
    logic                              i_in_valid     = 1'b0;
    logic                              o_in_ready;
    logic [7:0]                        i_data_byte    = '0;
    logic                              i_last_byte    = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_ready    = 1'b0;
    logic                              o_found;
    logic [wbps_pkg::RESULT_OFF_W-1:0] o_match_offset;

    bit quiet = 1'b0;
    int n_settings = 0;

    wildcard_byte_pattern_scan u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_match_offset (o_match_offset)
    );

    class scan_scoreboard;
        typedef struct {
            bit                              found;
            bit [wbps_pkg::RESULT_OFF_W-1:0] offset;
        } t_scan_result;

        bit [63:0]                    pat_word [4];
        bit [31:0]                    care;
        bit [wbps_pkg::LEN_CFG_W-1:0] length;
        bit [7:0]                     window [WINDOW_BYTES];
        bit [31:0]                    seen;
        bit                           reported;
        t_scan_result                 expected_q [$];
        int                           errors;
        int                           n_bytes;
        int                           n_buffers;
        int                           n_found;
        int                           n_missing;

        function new();
            foreach (pat_word[k]) pat_word[k] = '0;
            care = '0;
            length = wbps_pkg::LEN_CFG_W'(1);
            clear_buffer();
        endfunction

        function void clear_buffer();
            foreach (window[k]) window[k] = '0;
            seen = '0;
            reported = 1'b0;
        endfunction

        function void write_reg(wbps_pkg::t_cfg_reg idx, bit [63:0] value);
            case (idx)
                wbps_pkg::REG_PATTERN_WORD_0: pat_word[0] = value;
                wbps_pkg::REG_PATTERN_WORD_1: pat_word[1] = value;
                wbps_pkg::REG_PATTERN_WORD_2: pat_word[2] = value;
                wbps_pkg::REG_PATTERN_WORD_3: pat_word[3] = value;
                wbps_pkg::REG_CARE_MASK:      care = value[31:0];
                wbps_pkg::REG_PATTERN_LENGTH: length = value[wbps_pkg::LEN_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned span();
            if (length == 0) return 1;
            if (length > WINDOW_BYTES) return WINDOW_BYTES;
            return length;
        endfunction

        function bit [7:0] pat_byte(int j);
            return pat_word[j / 8][(j % 8) * 8 +: 8];
        endfunction

        // Note an accepted byte and queue the result it causes, if any.
        function void note_byte(bit [7:0] d, bit last);
            int unsigned  len;
            bit           hit;
            t_scan_result r;
            len = span();
            for (int i = WINDOW_BYTES - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = d;
            n_bytes++;
            if (seen != '1) seen++;
            if (!reported && seen >= len) begin
                hit = 1'b1;
                for (int j = 0; j < len; j++) begin
                    if (j < wbps_pkg::PAT_REG_BYTES && care[j]
                        && pat_byte(j) != window[len-1-j]) hit = 1'b0;
                end
                if (hit) begin
                    r.found = 1'b1;
                    r.offset = seen - len;
                    expected_q.push_back(r);
                    reported = 1'b1;
                    n_found++;
                end
            end
            if (last) begin
                n_buffers++;
                if (!reported) begin
                    r.found = 1'b0;
                    r.offset = '0;
                    expected_q.push_back(r);
                    n_missing++;
                end
                clear_buffer();
            end
        endfunction

        function void check_result(logic found, logic [wbps_pkg::RESULT_OFF_W-1:0] offset);
            t_scan_result r;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual found=%0b offset=%0d",
                         $time, found, offset);
                return;
            end
            r = expected_q.pop_front();
            if (found !== r.found) begin
                errors++;
                $display("%0t: found mismatch: expected %0b, actual %0b", $time, r.found, found);
            end
            if (offset !== r.offset) begin
                errors++;
                $display("%0t: offset mismatch: expected %0d, actual %0d",
                         $time, r.offset, offset);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    scan_scoreboard sb = new();

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        if (quiet) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_byte(input bit [7:0] d, input bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(d, last);
    endtask

    // Build one buffer: embed the pattern, a near miss, or plain noise.
    task automatic send_buffer(input int nbytes, input int mode);
        bit [7:0]    data [$];
        int unsigned len;
        int          pos;
        int          j;
        len = sb.span();
        for (int i = 0; i < nbytes; i++) data.push_back(8'($urandom_range(0, 255)));
        if (mode != 0 && nbytes >= len) begin
            pos = $urandom_range(0, nbytes - len);
            for (int k = 0; k < len; k++) begin
                if (sb.care[k]) data[pos+k] = sb.pat_byte(k);
            end
            if (mode == 2) begin
                j = $urandom_range(0, len - 1);
                if (sb.care[j]) data[pos+j] = ~data[pos+j];
            end
        end
        for (int i = 0; i < nbytes; i++) send_byte(data[i], i == nbytes - 1);
    endtask

    task automatic stop_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        stop_input();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input bit [63:0] w0, input bit [63:0] w1,
                                 input bit [63:0] w2, input bit [63:0] w3,
                                 input bit [63:0] care_w, input bit [63:0] len_w);
        bit [63:0]          vals [6];
        wbps_pkg::t_cfg_reg regs [6];
        drain();
        vals = '{w0, w1, w2, w3, care_w, len_w};
        regs = '{wbps_pkg::REG_PATTERN_WORD_0, wbps_pkg::REG_PATTERN_WORD_1,
                 wbps_pkg::REG_PATTERN_WORD_2, wbps_pkg::REG_PATTERN_WORD_3,
                 wbps_pkg::REG_CARE_MASK, wbps_pkg::REG_PATTERN_LENGTH};
        for (int k = 0; k < 6; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            sb.write_reg(regs[k], vals[k]);
        end
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    function automatic bit [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Receiver: check each result transfer, then stall for a drawn number of cycles.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result(o_found, o_match_offset);
                stall = draw_gap();
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int  start;
        int  pick;
        int  nbytes;
        bit  paused;
        bit [63:0] w [4];
        bit [63:0] care_w;
        bit [63:0] len_w;

        paused = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: length 1, all wildcards, so the first byte matches.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h5a, 1'b1);

        apply_setting(64'h0000_0000_7856_3412, '0, '0, '0, 64'hf, 64'd4);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b1);

        // Leading wildcard.
        apply_setting(64'h0000_0000_7856_3412, '0, '0, '0, 64'he, 64'd4);
        send_byte(8'h99, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'haa, 1'b1);

        // Length field zero acts as one; upper data bits are dropped.
        apply_setting('0, '1, '0, '1, 64'hffff_ffff_0000_0001, 64'h40);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);

        for (int phase = 0; sb.n_bytes < TOTAL_BYTES; phase++) begin
            foreach (w[k]) w[k] = rand_word();
            care_w = rand_word();
            len_w  = 64'($urandom_range(1, 32));
            case (phase % 6)
                0: begin
                    care_w = '1;
                    len_w  = 64'd32;
                end
                1: len_w = 64'd63;
                2: begin
                    foreach (w[k]) w[k] = '1;
                    len_w = 64'($urandom_range(1, 8));
                end
                3: begin
                    foreach (w[k]) w[k] = '0;
                    care_w = 64'hffff_ffff;
                    len_w  = 64'd33;
                end
                4: care_w = '0;
                default: len_w = 64'($urandom_range(0, 63));
            endcase
            apply_setting(w[0], w[1], w[2], w[3], care_w, len_w);
            quiet = (phase % 4 == 2);
            start = sb.n_bytes;
            while (sb.n_bytes - start < PHASE_BYTES) begin
                pick = $urandom_range(0, 9);
                nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 100)
                                                     : $urandom_range(1, 40);
                send_buffer(nbytes, (pick < 6) ? 1 : (pick < 8) ? 2 : 0);
                if (phase == 2 && !paused && sb.n_bytes - start >= PHASE_BYTES / 2) begin
                    stop_input();
                    while (sb.pending() != 0) @(posedge i_clk);
                    paused = 1'b1;
                end
            end
        end

        stop_input();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Scanned %0d bytes in %0d buffers over %0d pattern settings.",
                 sb.n_bytes, sb.n_buffers, n_settings);
        $display("Checked %0d match and %0d no-match results, %0d mismatches.",
                 sb.n_found, sb.n_missing, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/wbps_pkg.sv
rtl/wbps_match.sv
rtl/wildcard_byte_pattern_scan.sv
tb/tb_top.sv
